// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers included by i2c_master_byte_engine.
// Each check is clocked on clk and muted while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property expression every cycle.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ibe_pkg.sv -----
`timescale 1ns / 1ps

package ibe_pkg;

  localparam int ST_W = 5;

  localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] ST_SA    = 5'd1;
  localparam logic [ST_W-1:0] ST_SB    = 5'd2;
  localparam logic [ST_W-1:0] ST_PA    = 5'd3;
  localparam logic [ST_W-1:0] ST_PB    = 5'd4;
  localparam logic [ST_W-1:0] ST_WLO   = 5'd5;
  localparam logic [ST_W-1:0] ST_WHI   = 5'd6;
  localparam logic [ST_W-1:0] ST_WLO2  = 5'd7;
  localparam logic [ST_W-1:0] ST_WTAIL = 5'd8;
  localparam logic [ST_W-1:0] ST_KSET  = 5'd9;
  localparam logic [ST_W-1:0] ST_KHI   = 5'd10;
  localparam logic [ST_W-1:0] ST_POLL  = 5'd11;
  localparam logic [ST_W-1:0] ST_RLO   = 5'd12;
  localparam logic [ST_W-1:0] ST_RHI   = 5'd13;
  localparam logic [ST_W-1:0] ST_RAFT  = 5'd14;
  localparam logic [ST_W-1:0] ST_AKLO  = 5'd15;
  localparam logic [ST_W-1:0] ST_AKHI  = 5'd16;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] CFG_PHASE_TICKS     = 2'd0;
  localparam logic [1:0] CFG_ACK_PHASE_TICKS = 2'd1;
  localparam logic [1:0] CFG_ACK_POLL_LIMIT  = 2'd2;

  localparam logic [7:0] PHASE_TICKS_RST     = 8'd2;
  localparam logic [7:0] ACK_PHASE_TICKS_RST = 8'd1;
  localparam logic [9:0] ACK_POLL_LIMIT_RST  = 10'd250;

  localparam int CFG_DATA_W = 10;
  localparam int BITS_PER_BYTE = 8;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_phase_ticks;
    logic [9:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [ST_W-1:0] seq;
    logic [7:0]      phase;
    logic [3:0]      bitc;
    logic [7:0]      shift;
    logic [9:0]      poll;
    logic            scl;
    logic            sda;
    logic            drv;
    logic            ack_choice;
    logic            err;
    logic [7:0]      rx;
  } state_t;

  localparam state_t STATE_RST = '{
    seq: ST_IDLE, phase: 8'd0, bitc: 4'd0, shift: 8'd0, poll: 10'd0,
    scl: 1'b1, sda: 1'b1, drv: 1'b1, ack_choice: 1'b0, err: 1'b0, rx: 8'd0
  };

endpackage

// ----- hw/rtl/i2c_master_byte_engine.sv -----
`timescale 1ns / 1ps
// A request accepted into the input stage steps the sequencer into the result register
// once that register is free, so a stall on out_ready holds it in the input stage.
// Throughput: one tick request per cycle without stalls; a step is one pass of logic.
// in_ready drops only while both stages are full and out_ready is low.
// Reset (rst_n low, synchronous): sequencer idle with SCL/SDA high and driven,
// config back to phase 2, ack phase 1, poll limit 250, both pipeline stages empty.

module i2c_master_byte_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_cmd,
  input  logic [7:0]                     in_tx_byte,
  input  logic                           in_send_ack,
  input  logic                           in_sda_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_scl_level,
  output logic                           out_sda_level,
  output logic                           out_sda_drive,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic [7:0]                     out_rx_byte,
  output logic                           out_no_ack,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [ibe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ibe_pkg::*;
  `include "assert_macros.svh"

  // Register file for the timing and poll settings.
  cfg_t cfg;

  ibe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input stage: hold one tick request until the sequencer can step on it.
  logic       in_valid_r;
  logic [2:0] cmd_r;
  logic [7:0] tx_byte_r;
  logic       send_ack_r;
  logic       sda_in_r;

  // Sequencer state and result register.
  state_t     state_r;
  state_t     state_nxt;
  logic       done_nxt;
  logic       out_valid_r;
  logic       scl_r;
  logic       sda_lvl_r;
  logic       sda_drv_r;
  logic       busy_r;
  logic       done_r;
  logic [7:0] rx_r;
  logic       no_ack_r;

  logic       step_go;
  logic       res_free;

  // The result register frees up when empty or being taken this cycle.
  assign res_free = !out_valid_r || out_ready;
  // Step the sequencer whenever a request is held and the result slot frees up.
  assign step_go  = in_valid_r && res_free;
  // Take a new request when the input stage is empty or drains this cycle.
  assign in_ready = !in_valid_r || res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r      <= in_cmd;
      tx_byte_r  <= in_tx_byte;
      send_ack_r <= in_send_ack;
      sda_in_r   <= in_sda_in;
    end
  end

  // One sequencer step per request.
  ibe_step u_step (
    .cur      (state_r),
    .cfg      (cfg),
    .cmd      (cmd_r),
    .tx_byte  (tx_byte_r),
    .send_ack (send_ack_r),
    .sda_in   (sda_in_r),
    .nxt      (state_nxt),
    .done     (done_nxt)
  );

  // Advance the state only on a step; hold it across stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RST;
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the bus levels and status seen after this tick.
  always_ff @(posedge clk) begin
    if (step_go) begin
      scl_r     <= state_nxt.scl;
      sda_lvl_r <= state_nxt.drv ? state_nxt.sda : 1'b1;
      sda_drv_r <= state_nxt.drv;
      busy_r    <= (state_nxt.seq != ST_IDLE);
      done_r    <= done_nxt;
      rx_r      <= state_nxt.rx;
      no_ack_r  <= state_nxt.err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = scl_r;
  assign out_sda_level = sda_lvl_r;
  assign out_sda_drive = sda_drv_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_rx_byte   = rx_r;
  assign out_no_ack    = no_ack_r;

  `ASSERT_NEXT(a_step_gives_result, step_go, out_valid_r, "step did not produce a result")
  `ASSERT_IMPL(a_done_not_busy, out_valid_r && done_r, !busy_r, "done while still busy")
  `ASSERT_IMPL(a_release_high, out_valid_r && !sda_drv_r, sda_lvl_r, "released SDA not high")
  `ASSERT_IMPL(a_idle_no_count, state_r.seq == ST_IDLE, state_r.phase == 8'd0,
               "idle with a pending tick count")

endmodule

// ----- hw/rtl/ibe_cfg.sv -----
`timescale 1ns / 1ps

module ibe_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [ibe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ibe_pkg::cfg_t                   cfg
);
  import ibe_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks     <= PHASE_TICKS_RST;
      cfg_r.ack_phase_ticks <= ACK_PHASE_TICKS_RST;
      cfg_r.ack_poll_limit  <= ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_TICKS:     cfg_r.phase_ticks     <= cfg_wdata[7:0];
        CFG_ACK_PHASE_TICKS: cfg_r.ack_phase_ticks <= cfg_wdata[7:0];
        CFG_ACK_POLL_LIMIT:  cfg_r.ack_poll_limit  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/ibe_step.sv -----
`timescale 1ns / 1ps

module ibe_step (
  input  ibe_pkg::state_t cur,
  input  ibe_pkg::cfg_t   cfg,
  input  logic [2:0]      cmd,
  input  logic [7:0]      tx_byte,
  input  logic            send_ack,
  input  logic            sda_in,
  output ibe_pkg::state_t nxt,
  output logic            done
);
  import ibe_pkg::*;

  // Enter a bus segment: load its tick count and line levels.
  function automatic state_t enter_seg(state_t s, logic [ST_W-1:0] st,
                                       logic [7:0] p, logic [7:0] a);
    state_t r;
    r = s;
    r.seq   = st;
    r.phase = p;
    case (st)
      ST_SA:    begin r.scl = 1'b1; r.sda = 1'b1; r.drv = 1'b1; end
      ST_SB:    begin r.scl = 1'b1; r.sda = 1'b0; r.drv = 1'b1; end
      ST_PA:    begin r.scl = 1'b0; r.sda = 1'b0; r.drv = 1'b1; end
      ST_PB:    begin r.scl = 1'b1; r.sda = 1'b0; r.drv = 1'b1; end
      ST_WLO:   begin r.scl = 1'b0; r.sda = s.shift[7]; r.drv = 1'b1; end
      ST_WHI:   r.scl = 1'b1;
      ST_WLO2:  r.scl = 1'b0;
      ST_WTAIL: r.scl = 1'b0;
      ST_KSET: begin
        r.scl = 1'b0; r.sda = 1'b1; r.drv = 1'b0;
        r.phase = a;
        r.poll = '0;
      end
      ST_KHI: begin
        r.scl = 1'b1; r.sda = 1'b1; r.drv = 1'b0;
        r.phase = a;
      end
      ST_POLL:  r.phase = '0;
      ST_RLO:   begin r.scl = 1'b0; r.sda = 1'b1; r.drv = 1'b0; end
      ST_RHI:   r.scl = 1'b1;
      ST_RAFT:  r.scl = 1'b1;
      ST_AKLO:  begin r.scl = 1'b0; r.sda = !s.ack_choice; r.drv = 1'b1; end
      ST_AKHI:  r.scl = 1'b1;
      default: begin
        r.seq   = ST_IDLE;
        r.phase = '0;
      end
    endcase
    return r;
  endfunction

  logic [7:0] p_ticks;
  logic [7:0] a_ticks;
  logic [3:0] bitc_inc;
  logic       do_poll;
  state_t     s;

  // A zero tick count behaves as one tick.
  assign p_ticks = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
  assign a_ticks = (cfg.ack_phase_ticks == 8'd0) ? 8'd1 : cfg.ack_phase_ticks;
  assign bitc_inc = cur.bitc + 4'd1;

  always_comb begin
    s       = cur;
    done    = 1'b0;
    do_poll = 1'b0;
    if (cur.seq == ST_IDLE) begin
      case (cmd)
        CMD_START: s = enter_seg(s, ST_SA, p_ticks, a_ticks);
        CMD_STOP:  s = enter_seg(s, ST_PA, p_ticks, a_ticks);
        CMD_WRITE: begin
          s.err   = 1'b0;
          s.shift = tx_byte;
          s.bitc  = '0;
          s.poll  = '0;
          s = enter_seg(s, ST_WLO, p_ticks, a_ticks);
        end
        CMD_READ: begin
          s.ack_choice = send_ack;
          s.shift = '0;
          s.bitc  = '0;
          s = enter_seg(s, ST_RLO, p_ticks, a_ticks);
        end
        default: ;
      endcase
    end else if (cur.seq == ST_POLL) begin
      do_poll = 1'b1;
    end else begin
      s.phase = cur.phase - 8'd1;
      if (s.phase == 8'd0) begin
        case (cur.seq)
          ST_SA:    s = enter_seg(s, ST_SB, p_ticks, a_ticks);
          ST_SB: begin
            s.scl = 1'b0; s.seq = ST_IDLE; s.phase = '0; done = 1'b1;
          end
          ST_PA:    s = enter_seg(s, ST_PB, p_ticks, a_ticks);
          ST_PB: begin
            s.scl = 1'b1; s.sda = 1'b1; s.drv = 1'b1;
            s.seq = ST_IDLE; s.phase = '0; done = 1'b1;
          end
          ST_WLO:   s = enter_seg(s, ST_WHI, p_ticks, a_ticks);
          ST_WHI:   s = enter_seg(s, ST_WLO2, p_ticks, a_ticks);
          ST_WLO2: begin
            s.shift = {cur.shift[6:0], 1'b0};
            s.bitc  = bitc_inc;
            s = enter_seg(s, (bitc_inc < 4'(BITS_PER_BYTE)) ? ST_WLO : ST_WTAIL,
                          p_ticks, a_ticks);
          end
          ST_WTAIL: s = enter_seg(s, ST_KSET, p_ticks, a_ticks);
          ST_KSET:  s = enter_seg(s, ST_KHI, p_ticks, a_ticks);
          ST_KHI: begin
            s = enter_seg(s, ST_POLL, p_ticks, a_ticks);
            do_poll = 1'b1;
          end
          ST_RLO:   s = enter_seg(s, ST_RHI, p_ticks, a_ticks);
          ST_RHI: begin
            s.shift = {cur.shift[6:0], sda_in};
            s = enter_seg(s, ST_RAFT, p_ticks, a_ticks);
          end
          ST_RAFT: begin
            s.bitc = bitc_inc;
            if (bitc_inc < 4'(BITS_PER_BYTE)) begin
              s = enter_seg(s, ST_RLO, p_ticks, a_ticks);
            end else begin
              s.rx = cur.shift;
              s = enter_seg(s, ST_AKLO, p_ticks, a_ticks);
            end
          end
          ST_AKLO:  s = enter_seg(s, ST_AKHI, p_ticks, a_ticks);
          ST_AKHI: begin
            s.scl = 1'b0; s.seq = ST_IDLE; s.phase = '0; done = 1'b1;
          end
          default: begin
            s.seq = ST_IDLE; s.phase = '0; done = 1'b1;
          end
        endcase
      end
    end

    // Sample the acknowledge: low ends the write, too many highs force a stop.
    if (do_poll) begin
      if (!sda_in) begin
        s.scl = 1'b0; s.seq = ST_IDLE; s.phase = '0; done = 1'b1;
      end else if (s.poll >= cfg.ack_poll_limit) begin
        s.err = 1'b1;
        s = enter_seg(s, ST_PA, p_ticks, a_ticks);
      end else begin
        s.poll = s.poll + 10'd1;
      end
    end
    nxt = s;
  end

endmodule
